[rtl/pgw_pkg.sv]
// Shared types and constants for the pixel and glyph writer.
`default_nettype none

package pgw_pkg;

	localparam int GLYPH_SIZE = 8;
	localparam int CELLS      = GLYPH_SIZE * GLYPH_SIZE;
	localparam int CELL_W     = 6;
	localparam int COL_W      = 3;
	localparam int COORD_W    = 17;
	localparam int OFFSET_W   = 27;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic REQ_GLYPH = 1'b1;

	localparam logic [5:0] BPP_32 = 6'd32;
	localparam logic [5:0] BPP_24 = 6'd24;
	localparam logic [5:0] BPP_16 = 6'd16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROW_PITCH     = 3'd0,
		CFG_SCREEN_WIDTH  = 3'd1,
		CFG_SCREEN_HEIGHT = 3'd2,
		CFG_BITS_PER_PIX  = 3'd3,
		CFG_RED_LAYOUT    = 3'd4,
		CFG_GREEN_LAYOUT  = 3'd5,
		CFG_BLUE_LAYOUT   = 3'd6
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic emit;
	} dp_cmd_t;

	typedef struct packed {
		logic final_cell;
	} dp_status_t;

endpackage

`default_nettype wire

[rtl/pgw_ctrl.sv]
// Controller state machine that sequences request intake, setup and per-cell writes.
`default_nettype none

module pgw_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output pgw_pkg::dp_cmd_t    cmd,
	input  pgw_pkg::dp_status_t status
);
	import pgw_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				state_d = ST_RUN;
			end
			ST_RUN: begin
				if (cmd.emit && status.final_cell) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd.load  = 1'b0;
		cmd.setup = 1'b0;
		cmd.emit  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
			end
			ST_RUN: begin
				cmd.emit = !out_valid_q || out_ready;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/pgw_datapath.sv]
// Datapath with configuration registers, color packing, offset stepping and the result register.
`default_nettype none

module pgw_datapath #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [pgw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pgw_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             req_type,
	input  logic signed [15:0]               x_pos,
	input  logic signed [15:0]               y_pos,
	input  logic [31:0]                      fg_color,
	input  logic [31:0]                      bg_color,
	input  logic                             opaque,
	input  logic [63:0]                      glyph_rows,
	input  pgw_pkg::dp_cmd_t                 cmd,
	output pgw_pkg::dp_status_t              status,
	output logic                             write_enable,
	output logic [pgw_pkg::OFFSET_W-1:0]     byte_offset,
	output logic [31:0]                      write_data,
	output logic [2:0]                       byte_count,
	output logic                             last
);
	import pgw_pkg::*;

	localparam logic [15:0] MAX_W = 16'(MAX_WIDTH);
	localparam logic [15:0] MAX_H = 16'(MAX_HEIGHT);

	function automatic logic [31:0] pack_channel(input logic [7:0] level,
		input logic [8:0] layout);
		logic [4:0] pos;
		logic [3:0] size;
		logic [8:0] ones;
		pos  = layout[4:0];
		size = (layout[8:5] > 4'd8) ? 4'd8 : layout[8:5];
		ones = (9'd1 << size) - 9'd1;
		return ({24'b0, level} << pos) & ({24'b0, ones[7:0]} << pos);
	endfunction

	logic [13:0] row_pitch_q;
	logic [12:0] screen_width_q;
	logic [12:0] screen_height_q;
	logic [5:0]  bits_per_pixel_q;
	logic [8:0]  red_layout_q;
	logic [8:0]  green_layout_q;
	logic [8:0]  blue_layout_q;

	logic                      req_glyph_q;
	logic                      opaque_q;
	logic [63:0]               held_glyph_q;
	logic [31:0]               fg_raw_q;
	logic [31:0]               bg_raw_q;
	logic [31:0]               held_fg_pixel_q;
	logic [31:0]               held_bg_pixel_q;
	logic signed [COORD_W-1:0] x0_q;
	logic signed [COORD_W-1:0] cur_x_q;
	logic signed [COORD_W-1:0] cur_y_q;
	logic [OFFSET_W-1:0]       row_base_q;
	logic [OFFSET_W-1:0]       col_start_q;
	logic [OFFSET_W-1:0]       col_off_q;
	logic [CELL_W-1:0]         cell_index_q;

	logic                      write_enable_q;
	logic [OFFSET_W-1:0]       byte_offset_q;
	logic [31:0]               write_data_q;
	logic [2:0]                byte_count_q;
	logic                      last_q;

	logic [6:0]         bpp_sum;
	logic [3:0]         stride;
	logic signed [31:0] row_prod;
	logic signed [21:0] col_prod;
	logic [15:0]        lim_w;
	logic [15:0]        lim_h;
	logic               cell_set;
	logic               use_fg;
	logic               draw;
	logic               in_bounds;
	logic               en;
	logic [31:0]        pixel;
	logic [31:0]        data_sized;
	logic [2:0]         count;
	logic [OFFSET_W-1:0] cell_offset;
	logic               final_cell;

	assign bpp_sum  = {1'b0, bits_per_pixel_q} + 7'd7;
	assign stride   = bpp_sum[6:3];
	assign row_prod = cur_y_q * $signed({1'b0, row_pitch_q});
	assign col_prod = x0_q * $signed({1'b0, stride});

	assign lim_w = ({3'b0, screen_width_q} < MAX_W) ? {3'b0, screen_width_q} : MAX_W;
	assign lim_h = ({3'b0, screen_height_q} < MAX_H) ? {3'b0, screen_height_q} : MAX_H;

	assign cell_set  = held_glyph_q[cell_index_q];
	assign use_fg    = (req_glyph_q != REQ_GLYPH) || cell_set;
	assign draw      = use_fg || opaque_q;
	assign in_bounds = !cur_x_q[COORD_W-1] && !cur_y_q[COORD_W-1]
		&& (cur_x_q[15:0] < lim_w) && (cur_y_q[15:0] < lim_h);
	assign en        = draw && in_bounds;
	assign pixel     = use_fg ? held_fg_pixel_q : held_bg_pixel_q;
	assign cell_offset = row_base_q + col_off_q;
	assign final_cell  = (req_glyph_q != REQ_GLYPH) || (cell_index_q == CELL_W'(CELLS - 1));

	always_comb begin
		unique case (bits_per_pixel_q)
			BPP_32: begin
				count      = 3'd4;
				data_sized = pixel;
			end
			BPP_24: begin
				count      = 3'd3;
				data_sized = {8'b0, pixel[23:0]};
			end
			BPP_16: begin
				count      = 3'd2;
				data_sized = {16'b0, pixel[15:0]};
			end
			default: begin
				count      = 3'd1;
				data_sized = {24'b0, pixel[7:0]};
			end
		endcase
	end

	assign status.final_cell = final_cell;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pitch_q      <= '0;
			screen_width_q   <= '0;
			screen_height_q  <= '0;
			bits_per_pixel_q <= BPP_32;
			red_layout_q     <= '0;
			green_layout_q   <= '0;
			blue_layout_q    <= '0;
			cell_index_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROW_PITCH:     row_pitch_q      <= cfg_data[13:0];
					CFG_SCREEN_WIDTH:  screen_width_q   <= cfg_data[12:0];
					CFG_SCREEN_HEIGHT: screen_height_q  <= cfg_data[12:0];
					CFG_BITS_PER_PIX:  bits_per_pixel_q <= cfg_data[5:0];
					CFG_RED_LAYOUT:    red_layout_q     <= cfg_data[8:0];
					CFG_GREEN_LAYOUT:  green_layout_q   <= cfg_data[8:0];
					CFG_BLUE_LAYOUT:   blue_layout_q    <= cfg_data[8:0];
					default: begin
					end
				endcase
			end
			if (cmd.load) begin
				cell_index_q <= '0;
			end else if (cmd.emit) begin
				cell_index_q <= cell_index_q + CELL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_glyph_q  <= req_type;
			opaque_q     <= opaque;
			held_glyph_q <= glyph_rows;
			fg_raw_q     <= fg_color;
			bg_raw_q     <= bg_color;
			x0_q         <= {x_pos[15], x_pos};
			cur_x_q      <= {x_pos[15], x_pos};
			cur_y_q      <= {y_pos[15], y_pos};
		end
		if (cmd.setup) begin
			held_fg_pixel_q <= pack_channel(fg_raw_q[23:16], red_layout_q)
				| pack_channel(fg_raw_q[15:8], green_layout_q)
				| pack_channel(fg_raw_q[7:0], blue_layout_q);
			held_bg_pixel_q <= pack_channel(bg_raw_q[23:16], red_layout_q)
				| pack_channel(bg_raw_q[15:8], green_layout_q)
				| pack_channel(bg_raw_q[7:0], blue_layout_q);
			row_base_q  <= row_prod[OFFSET_W-1:0];
			col_start_q <= {{(OFFSET_W-22){col_prod[21]}}, col_prod};
			col_off_q   <= {{(OFFSET_W-22){col_prod[21]}}, col_prod};
		end
		if (cmd.emit) begin
			write_enable_q <= en;
			byte_offset_q  <= en ? cell_offset : '0;
			write_data_q   <= en ? data_sized : '0;
			byte_count_q   <= count;
			last_q         <= final_cell;
			if (cell_index_q[COL_W-1:0] == COL_W'(GLYPH_SIZE - 1)) begin
				cur_x_q    <= x0_q;
				cur_y_q    <= cur_y_q + COORD_W'(1);
				row_base_q <= row_base_q + {{(OFFSET_W-14){1'b0}}, row_pitch_q};
				col_off_q  <= col_start_q;
			end else begin
				cur_x_q   <= cur_x_q + COORD_W'(1);
				col_off_q <= col_off_q + {{(OFFSET_W-4){1'b0}}, stride};
			end
		end
	end

	assign write_enable = write_enable_q;
	assign byte_offset  = byte_offset_q;
	assign write_data   = write_data_q;
	assign byte_count   = byte_count_q;
	assign last         = last_q;

endmodule

`default_nettype wire

[rtl/pixel_and_glyph_writer.sv]
// Top level of the pixel and 8x8 glyph framebuffer writer.
//
//   channel  direction  handshake              payload
//   cfg      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//   in       in         in_valid / in_ready    req_type .. glyph_rows
//   out      out        out_valid / out_ready  write_enable .. last
//
// A pixel request passes through the setup and run states; the run state registers its
// single result and returns to idle, so the input is free again as the result shows.
// A glyph request gives 64 results, one per cycle while the output is not stalled,
// after a setup state in which the row and column offset products are formed.
// Stalls on the output hold the result register and pause the cell walk.
// Reset loads bits_per_pixel with 32 and clears the other configuration registers and the cell index.
`default_nettype none

module pixel_and_glyph_writer #(
	parameter int MAX_WIDTH  = 4096,
	parameter int MAX_HEIGHT = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [pgw_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pgw_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            req_type,
	input  logic signed [15:0]              x_pos,
	input  logic signed [15:0]              y_pos,
	input  logic [31:0]                     fg_color,
	input  logic [31:0]                     bg_color,
	input  logic                            opaque,
	input  logic [63:0]                     glyph_rows,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            write_enable,
	output logic [pgw_pkg::OFFSET_W-1:0]    byte_offset,
	output logic [31:0]                     write_data,
	output logic [2:0]                      byte_count,
	output logic                            last
);
	import pgw_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;
	logic       cfg_we;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;

	pgw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.status    (status)
	);

	pgw_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.req_type     (req_type),
		.x_pos        (x_pos),
		.y_pos        (y_pos),
		.fg_color     (fg_color),
		.bg_color     (bg_color),
		.opaque       (opaque),
		.glyph_rows   (glyph_rows),
		.cmd          (cmd),
		.status       (status),
		.write_enable (write_enable),
		.byte_offset  (byte_offset),
		.write_data   (write_data),
		.byte_count   (byte_count),
		.last         (last)
	);

endmodule

`default_nettype wire

[rtl/pgw_checker.sv]
// Port-level assertions for the pixel and glyph writer, bound to the top level.
`default_nettype none

module pgw_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic                            write_enable,
	input logic [pgw_pkg::OFFSET_W-1:0]    byte_offset,
	input logic [31:0]                     write_data,
	input logic [2:0]                      byte_count,
	input logic                            last
);

	// A request is worked on alone, so intake closes right after an item.
	a_one_request: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while a request is in progress");

	// A disabled write carries neither an address nor data.
	a_disabled_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> byte_offset == '0 && write_data == '0)
		else $error("disabled write has nonzero offset or data");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> byte_count != 3'd0 && byte_count <= 3'd4)
		else $error("byte count out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(byte_offset)
			&& $stable(write_data) && $stable(last))
		else $error("stalled result changed");

endmodule

bind pixel_and_glyph_writer pgw_checker u_pgw_checker (.*);

`default_nettype wire
